// File: sv/ros_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ros_pkg: shared types and constants of the ray / oriented box slab test
// Field widths, fixed-point constants, register indexes and reset values.
// ----------------------------------------------------------------------------
package ros_pkg;

	// fixed-point formats
	localparam int DIR_FRAC   = 14;
	localparam int AXIS_FRAC  = 12;

	// field widths
	localparam int POS_W      = 32;
	localparam int DIR_W      = 16;
	localparam int AXIS_W     = 16;
	localparam int HALF_W     = 16;
	localparam int DIST_W     = 25;

	// datapath widths
	localparam int D_W        = POS_W + 1;         // centre - origin
	localparam int PE_W       = AXIS_W + D_W;      // axis component * offset
	localparam int E_W        = PE_W + 2;          // sum of three
	localparam int PF_W       = AXIS_W + DIR_W;    // axis component * direction
	localparam int F_W        = PF_W + 2;          // sum of three
	localparam int NUM_W      = E_W + 1;           // e -/+ half extent
	localparam int AF_W       = F_W;               // magnitude of f

	// parallel test: 1000 * |f| > 2^26
	localparam int PAR_DIV    = 1000;
	localparam int PAR_W      = AF_W + 10;
	localparam logic [PAR_W-1:0] PAR_THRESH = PAR_W'(1) << (DIR_FRAC + AXIS_FRAC);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_CENTER_Z   = 3'd2,
		REG_AXIS_ONE   = 3'd3,
		REG_AXIS_TWO   = 3'd4,
		REG_AXIS_THREE = 3'd5,
		REG_HALF_EXT   = 3'd6
	} cfg_reg_t;

	localparam logic [CFG_DATA_W-1:0] AXIS_ONE_RST   = 48'h0000_0000_1000;
	localparam logic [CFG_DATA_W-1:0] AXIS_TWO_RST   = 48'h0000_1000_0000;
	localparam logic [CFG_DATA_W-1:0] AXIS_THREE_RST = 48'h1000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] HALF_EXT_RST   = 48'h012C_012C_012C;

	// box description as seen by the datapath
	typedef struct packed {
		logic [2:0][POS_W-1:0]      center;
		logic [2:0][CFG_DATA_W-1:0] axis;
		logic [CFG_DATA_W-1:0]      half;
	} cfg_t;

	// per-axis flags that travel beside the dividers
	typedef struct packed {
		logic act;       // slab not parallel to the ray
		logic smiss;     // origin outside a parallel slab
		logic neg_lo;    // sign of the first plane distance
		logic neg_hi;    // sign of the second plane distance
	} axis_sb_t;

endpackage
`default_nettype wire

// File: sv/ros_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ros_if: channel interfaces of the ray / oriented box slab test
// Ray input channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface ros_ray_if;
	logic                                valid;
	logic                                ready;
	logic signed [ros_pkg::POS_W-1:0]    origin_x;
	logic signed [ros_pkg::POS_W-1:0]    origin_y;
	logic signed [ros_pkg::POS_W-1:0]    origin_z;
	logic signed [ros_pkg::DIR_W-1:0]    dir_x;
	logic signed [ros_pkg::DIR_W-1:0]    dir_y;
	logic signed [ros_pkg::DIR_W-1:0]    dir_z;

	modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

interface ros_res_if;
	logic                           valid;
	logic                           ready;
	logic                           hit;
	logic [ros_pkg::DIST_W-1:0]     hit_distance;

	modport source(output valid, hit, hit_distance, input ready);
	modport sink(input valid, hit, hit_distance, output ready);
endinterface

interface ros_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [ros_pkg::CFG_IDX_W-1:0]      index;
	logic [ros_pkg::CFG_DATA_W-1:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/ros_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ros_cfg_regs: box configuration registers
// Takes register writes from the configuration channel, holds the box.
// ----------------------------------------------------------------------------
module ros_cfg_regs (
	input  wire logic    clk,
	input  wire logic    arst_n,
	ros_cfg_if.sink      cfg,
	output ros_pkg::cfg_t box
);

	logic [ros_pkg::POS_W-1:0]      cx_q, cy_q, cz_q;
	logic [ros_pkg::CFG_DATA_W-1:0] a1_q, a2_q, a3_q, half_q;

	assign cfg.ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q   <= '0;
			cy_q   <= '0;
			cz_q   <= '0;
			a1_q   <= ros_pkg::AXIS_ONE_RST;
			a2_q   <= ros_pkg::AXIS_TWO_RST;
			a3_q   <= ros_pkg::AXIS_THREE_RST;
			half_q <= ros_pkg::HALF_EXT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				ros_pkg::REG_CENTER_X:   cx_q   <= cfg.data[ros_pkg::POS_W-1:0];
				ros_pkg::REG_CENTER_Y:   cy_q   <= cfg.data[ros_pkg::POS_W-1:0];
				ros_pkg::REG_CENTER_Z:   cz_q   <= cfg.data[ros_pkg::POS_W-1:0];
				ros_pkg::REG_AXIS_ONE:   a1_q   <= cfg.data;
				ros_pkg::REG_AXIS_TWO:   a2_q   <= cfg.data;
				ros_pkg::REG_AXIS_THREE: a3_q   <= cfg.data;
				ros_pkg::REG_HALF_EXT:   half_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign box.center = {cz_q, cy_q, cx_q};
	assign box.axis   = {a3_q, a2_q, a1_q};
	assign box.half   = half_q;

endmodule
`default_nettype wire

// File: sv/ros_dot.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ros_dot: projection front end, three register stages
// s1 offset from origin to centre, s2 the eighteen products, s3 the sums
// e = axis . (centre - origin) and f = axis . direction for each axis.
// ----------------------------------------------------------------------------
module ros_dot (
	input  wire logic                                    clk,
	input  wire logic                                    en,
	input  wire ros_pkg::cfg_t                           box,
	input  wire logic signed [2:0][ros_pkg::POS_W-1:0]   origin,
	input  wire logic signed [2:0][ros_pkg::DIR_W-1:0]   dir,
	output logic signed [2:0][ros_pkg::E_W-1:0]          e_s3,
	output logic signed [2:0][ros_pkg::F_W-1:0]          f_s3
);

	logic signed [2:0][ros_pkg::D_W-1:0]         d_s1;
	logic signed [2:0][ros_pkg::DIR_W-1:0]       dir_s1;
	logic signed [2:0][2:0][ros_pkg::PE_W-1:0]   pe_s2;
	logic signed [2:0][2:0][ros_pkg::PF_W-1:0]   pf_s2;

	// offset from origin to centre
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= ros_pkg::D_W'($signed(box.center[i])) -
					ros_pkg::D_W'($signed(origin[i]));
			end
			dir_s1 <= dir;
		end
	end

	// component products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					pe_s2[k][i] <= ros_pkg::PE_W'($signed(box.axis[k][16*i +: 16])) *
						ros_pkg::PE_W'($signed(d_s1[i]));
					pf_s2[k][i] <= ros_pkg::PF_W'($signed(box.axis[k][16*i +: 16])) *
						ros_pkg::PF_W'($signed(dir_s1[i]));
				end
			end
		end
	end

	// dot product sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				e_s3[k] <= ros_pkg::E_W'($signed(pe_s2[k][0])) +
					ros_pkg::E_W'($signed(pe_s2[k][1])) +
					ros_pkg::E_W'($signed(pe_s2[k][2]));
				f_s3[k] <= ros_pkg::F_W'($signed(pf_s2[k][0])) +
					ros_pkg::F_W'($signed(pf_s2[k][1])) +
					ros_pkg::F_W'($signed(pf_s2[k][2]));
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/ros_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ros_div: pipelined restoring divider for one plane distance
// Computes floor(num * 2^14 / den) one quotient bit per stage. A first stage
// flags quotients of 2^QB and above, which the caller clamps.
// ----------------------------------------------------------------------------
module ros_div #(
	parameter int QB = 26
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [ros_pkg::NUM_W-1:0]   num,
	input  wire logic [ros_pkg::AF_W-1:0]    den,
	output logic [QB-1:0]                    quo,
	output logic                             ovf
);

	localparam int NW = ros_pkg::NUM_W + ros_pkg::DIR_FRAC;
	localparam int DW = ros_pkg::AF_W + QB;
	localparam int RW = (NW > DW ? NW : DW) + 1;

	logic [RW-1:0]              rem_s [0:QB-1];
	logic [ros_pkg::AF_W-1:0]   den_s [0:QB-1];
	logic [QB-1:0]              q_s   [1:QB];
	logic                       ovf_s [0:QB];

	// range check stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= RW'(num) << ros_pkg::DIR_FRAC;
			den_s[0] <= den;
			ovf_s[0] <= (RW'(num) << ros_pkg::DIR_FRAC) >= (RW'(den) << QB);
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 1; j <= QB; j++) begin : g_bit
		logic [RW-1:0] dsh;
		logic          take;
		logic [QB-1:0] q_prev;

		assign dsh  = RW'(den_s[j-1]) << (QB - j);
		assign take = rem_s[j-1] >= dsh;

		if (j == 1) begin : g_first
			assign q_prev = '0;
		end else begin : g_next
			assign q_prev = q_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[j]   <= q_prev | (take ? (QB'(1) << (QB - j)) : '0);
				ovf_s[j] <= ovf_s[j-1];
			end
		end

		if (j < QB) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j] <= take ? (rem_s[j-1] - dsh) : rem_s[j-1];
					den_s[j] <= den_s[j-1];
				end
			end
		end
	end

	assign quo = q_s[QB];
	assign ovf = ovf_s[QB];

endmodule
`default_nettype wire

// File: sv/ray_obb_slab_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_obb_slab_test: ray versus oriented box, slab method
// Tests one ray per cycle unless stalled, against the configured box.
// ----------------------------------------------------------------------------
// Channels: ray (origin Q24.8, direction Q2.14) in, result (hit, near
// distance Q17.8, zero on a miss) out, one result per ray, in order.
// The box (centre, three axes, half extents) is written through cfg, which
// is always ready; write it only while no ray is in flight.
// Throughput: one ray per cycle while no result waits on res.ready.
// Pipeline: POS_FRAC_BITS + 27 register stages (35 at the default), from the
// first input register to the result register. The stage count is set
// by the six plane-distance dividers, one quotient bit per stage.
// Stall: when a result waits on a low res.ready the whole pipeline holds,
// and ray.ready is low; otherwise rays are taken while results wait nowhere.
// Reset: all valid bits clear, the box returns to a unit-axis cube of half
// size 300 centred at the origin.
// ----------------------------------------------------------------------------
module ray_obb_slab_test #(
	parameter int POS_FRAC_BITS = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ros_ray_if.sink    ray,
	ros_res_if.source  res,
	ros_cfg_if.sink    cfg
);

	localparam int QB = 18 + POS_FRAC_BITS;        // quotient bits
	localparam int TW = QB + 1;                    // signed distance width
	localparam int HS_SH = POS_FRAC_BITS + ros_pkg::AXIS_FRAC;
	localparam longint LIMIT_L = 64'd100000 << POS_FRAC_BITS;
	localparam logic signed [TW-1:0] LIMIT = TW'(LIMIT_L);
	localparam logic [QB-1:0] CAP = QB'(LIMIT_L + 1);

	ros_pkg::cfg_t box;
	logic          adv;

	logic                                    v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [2:0][ros_pkg::E_W-1:0]     e_s3;
	logic signed [2:0][ros_pkg::F_W-1:0]     f_s3;

	logic signed [2:0][ros_pkg::NUM_W-1:0]   lo_s4, hi_s4;
	logic [2:0][ros_pkg::AF_W-1:0]           af_s4;
	logic [2:0]                              fneg_s4, smiss_s4;

	logic [2:0][ros_pkg::NUM_W-1:0]          alo_s5, ahi_s5;
	logic [2:0][ros_pkg::AF_W-1:0]           af_s5;
	ros_pkg::axis_sb_t [2:0]                 sb_s5;

	ros_pkg::axis_sb_t [2:0]                 sb_s [0:QB];
	logic                                    vd_s [0:QB];
	logic [2:0][QB-1:0]                      qlo, qhi;
	logic [2:0]                              olo, ohi;

	logic                                    v_sa;
	logic signed [2:0][TW-1:0]               tlo_sa, thi_sa;
	logic [2:0]                              act_sa;
	logic                                    miss_sa;

	logic                                    v_sb;
	logic signed [TW-1:0]                    tmin_sb, tmax_sb;
	logic                                    miss_sb;

	logic                                    res_valid_q, hit_q;
	logic [ros_pkg::DIST_W-1:0]              dist_q;

	logic signed [TW-1:0]                    tmin_c, tmax_c;

	// pipeline advances unless a result is held
	assign adv       = !res_valid_q || res.ready;
	assign ray.ready = adv;

	ros_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.box    (box)
	);

	ros_dot u_dot (
		.clk    (clk),
		.en     (adv),
		.box    (box),
		.origin ({ray.origin_z, ray.origin_y, ray.origin_x}),
		.dir    ({ray.dir_z, ray.dir_y, ray.dir_x}),
		.e_s3   (e_s3),
		.f_s3   (f_s3)
	);

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= ray.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// plane numerators and parallel-slab containment
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				logic signed [ros_pkg::NUM_W-1:0] ev, hs;
				ev = ros_pkg::NUM_W'($signed(e_s3[k]));
				hs = $signed(ros_pkg::NUM_W'(box.half[16*k +: 16]) << HS_SH);
				lo_s4[k]    <= ev - hs;
				hi_s4[k]    <= ev + hs;
				smiss_s4[k] <= (ev > hs) || (ev < -hs);
				fneg_s4[k]  <= f_s3[k][ros_pkg::F_W-1];
				af_s4[k]    <= f_s3[k][ros_pkg::F_W-1] ? ros_pkg::AF_W'(-f_s3[k]) :
					ros_pkg::AF_W'(f_s3[k]);
			end
		end
	end

	// magnitudes, quotient signs and the parallel test
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				alo_s5[k] <= lo_s4[k][ros_pkg::NUM_W-1] ? ros_pkg::NUM_W'(-lo_s4[k]) :
					ros_pkg::NUM_W'(lo_s4[k]);
				ahi_s5[k] <= hi_s4[k][ros_pkg::NUM_W-1] ? ros_pkg::NUM_W'(-hi_s4[k]) :
					ros_pkg::NUM_W'(hi_s4[k]);
				af_s5[k]  <= af_s4[k];
				sb_s5[k].act    <= (ros_pkg::PAR_W'(af_s4[k]) *
					ros_pkg::PAR_W'(ros_pkg::PAR_DIV)) > ros_pkg::PAR_THRESH;
				sb_s5[k].smiss  <= smiss_s4[k];
				sb_s5[k].neg_lo <= lo_s4[k][ros_pkg::NUM_W-1] ^ fneg_s4[k];
				sb_s5[k].neg_hi <= hi_s4[k][ros_pkg::NUM_W-1] ^ fneg_s4[k];
			end
		end
	end

	// six plane-distance dividers
	for (genvar k = 0; k < 3; k++) begin : g_axis
		ros_div #(.QB(QB)) u_div_lo (
			.clk (clk),
			.en  (adv),
			.num (alo_s5[k]),
			.den (af_s5[k]),
			.quo (qlo[k]),
			.ovf (olo[k])
		);
		ros_div #(.QB(QB)) u_div_hi (
			.clk (clk),
			.en  (adv),
			.num (ahi_s5[k]),
			.den (af_s5[k]),
			.quo (qhi[k]),
			.ovf (ohi[k])
		);
	end

	// flags delayed alongside the dividers
	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s[0] <= sb_s5;
			for (int j = 1; j <= QB; j++) begin
				sb_s[j] <= sb_s[j-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= QB; j++) begin
				vd_s[j] <= 1'b0;
			end
		end else if (adv) begin
			vd_s[0] <= v_s5;
			for (int j = 1; j <= QB; j++) begin
				vd_s[j] <= vd_s[j-1];
			end
		end
	end

	// clamp, sign and sort the two plane distances of each slab
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				logic [QB-1:0]        cl, ch;
				logic signed [TW-1:0] t1, t2;
				cl = (olo[k] || qlo[k] > CAP) ? CAP : qlo[k];
				ch = (ohi[k] || qhi[k] > CAP) ? CAP : qhi[k];
				t1 = sb_s[QB][k].neg_lo ? -$signed(TW'(cl)) : $signed(TW'(cl));
				t2 = sb_s[QB][k].neg_hi ? -$signed(TW'(ch)) : $signed(TW'(ch));
				tlo_sa[k] <= (t1 > t2) ? t2 : t1;
				thi_sa[k] <= (t1 > t2) ? t1 : t2;
				act_sa[k] <= sb_s[QB][k].act;
			end
			miss_sa <= (!sb_s[QB][0].act && sb_s[QB][0].smiss) ||
				(!sb_s[QB][1].act && sb_s[QB][1].smiss) ||
				(!sb_s[QB][2].act && sb_s[QB][2].smiss);
		end
	end

	// narrow the interval over the active slabs
	always_comb begin
		tmin_c = '0;
		tmax_c = LIMIT;
		for (int k = 0; k < 3; k++) begin
			if (act_sa[k] && $signed(tlo_sa[k]) > tmin_c) begin
				tmin_c = tlo_sa[k];
			end
			if (act_sa[k] && $signed(thi_sa[k]) < tmax_c) begin
				tmax_c = thi_sa[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tmin_sb <= tmin_c;
			tmax_sb <= tmax_c;
			miss_sb <= miss_sa;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q  <= !miss_sb && (tmax_sb >= tmin_sb);
			dist_q <= (!miss_sb && (tmax_sb >= tmin_sb)) ?
				ros_pkg::DIST_W'($unsigned(tmin_sb)) : '0;
		end
	end

	// valid bits of the back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sa        <= 1'b0;
			v_sb        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_sa        <= vd_s[QB];
			v_sb        <= v_sa;
			res_valid_q <= v_sb;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.hit          = hit_q;
	assign res.hit_distance = dist_q;

endmodule
`default_nettype wire
